FILE: design/sktbl_pkg.sv
// Types and codes shared by the sorted key table search block.
package sktbl_pkg;

    localparam int KEY_BITS = 32;
    localparam int HANDLE_PORT_BITS = 16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [1:0]                        opcode;
        logic signed [KEY_BITS-1:0]        key;
        logic [HANDLE_PORT_BITS-1:0]       handle;
    } cmd_t;

    typedef struct packed {
        logic [1:0]                        status;
        logic [7:0]                        position;
        logic [HANDLE_PORT_BITS-1:0]       found_handle;
        logic [8:0]                        entry_total;
    } result_t;

endpackage

FILE: design/sorted_key_table_search.sv
// Top level of the sorted key table: binary search, ordered insert and remove.
//
// The block holds up to TABLE_DEPTH unique signed keys with their handles in
// ascending key order, in one synchronous memory with a single read and a
// single write port. An item is taken when start is high and busy is low; its
// result appears for exactly one cycle with done high and cannot be held off,
// and a new item may be started in that same cycle. A lookup runs up to
// ceil(log2(entries+1)) binary search steps, each reading the middle entry
// and then narrowing the bounds. An insert then moves each entry above the
// insert point up by one and places the new key; a remove moves each entry
// above the removed one down by one. The worst case, an insert at the bottom
// of a table holding TABLE_DEPTH-1 keys, is set by moving entries through the
// single memory port one per cycle. The table needs no clearing after reset,
// since only entries below the entry count are ever read.
module sorted_key_table_search #(
    parameter int TABLE_DEPTH = 256,
    parameter int HANDLE_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  sktbl_pkg::cmd_t    command,
    output logic               done,
    output sktbl_pkg::result_t result
);
    import sktbl_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int HS = (HANDLE_BITS < HANDLE_PORT_BITS) ? HANDLE_BITS : HANDLE_PORT_BITS;
    localparam int WW = KEY_BITS + HS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_READ,
        S_INS_SHIFT,
        S_INS_WRITE,
        S_REM_SHIFT
    } state_t;

    state_t                     state_reg, state_next;
    logic [1:0]                 op_reg, op_next;
    logic signed [KEY_BITS-1:0] key_reg, key_next;
    logic [HS-1:0]              handle_reg, handle_next;
    logic [CW-1:0]              lo_reg, lo_next;
    logic [CW-1:0]              hi_reg, hi_next;
    logic [CW-1:0]              mid_reg, mid_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic                       hit_reg, hit_next;
    logic [HS-1:0]              fh_reg, fh_next;
    logic [CW-1:0]              count_reg, count_next;
    logic                       done_reg, done_next;
    result_t                    result_reg, result_next;

    logic [WW-1:0]              table_mem [TABLE_DEPTH];
    logic [WW-1:0]              mem_rdata_reg;
    logic                       mem_we, mem_re;
    logic [AW-1:0]              mem_waddr, mem_raddr;
    logic [WW-1:0]              mem_wdata;

    logic signed [KEY_BITS-1:0] rd_key;
    logic [HS-1:0]              rd_handle;
    logic [CW-1:0]              mid_calc;

    assign rd_key    = mem_rdata_reg[HS +: KEY_BITS];
    assign rd_handle = mem_rdata_reg[HS-1:0];
    assign mid_calc  = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    function automatic result_t make_result(input logic [1:0] st, input logic [CW-1:0] pos,
                                            input logic [HS-1:0] fh, input logic [CW-1:0] total);
        result_t r;
        r.status       = st;
        r.position     = 8'(pos);
        r.found_handle = HANDLE_PORT_BITS'(fh);
        r.entry_total  = 9'(total);
        return r;
    endfunction

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        handle_next = handle_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        ptr_next    = ptr_reg;
        hit_next    = hit_reg;
        fh_next     = fh_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = '0;
        mem_raddr   = '0;
        mem_wdata   = mem_rdata_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next     = command.opcode;
                    key_next    = command.key;
                    handle_next = HS'(command.handle);
                    lo_next     = '0;
                    hi_next     = count_reg;
                    hit_next    = 1'b0;
                    fh_next     = '0;
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(mid_calc);
                    mid_next   = mid_calc;
                    state_next = S_READ;
                end
                else
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    unique case (op_reg)
                        OP_INSERT:
                        begin
                            if (hit_reg)
                            begin
                                result_next = make_result(ST_DUPLICATE, '0, '0, count_reg);
                            end
                            else if (count_reg >= CW'(TABLE_DEPTH))
                            begin
                                result_next = make_result(ST_FULL, '0, '0, count_reg);
                            end
                            else if (lo_reg == count_reg)
                            begin
                                done_next  = 1'b0;
                                state_next = S_INS_WRITE;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(count_reg - CW'(1));
                                ptr_next   = AW'(count_reg - CW'(1));
                                state_next = S_INS_SHIFT;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!hit_reg)
                            begin
                                result_next = make_result(ST_NOT_FOUND, '0, '0, count_reg);
                            end
                            else if (lo_reg + CW'(1) == count_reg)
                            begin
                                count_next  = count_reg - CW'(1);
                                result_next = make_result(ST_OK, lo_reg, fh_reg,
                                                          count_reg - CW'(1));
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(lo_reg + CW'(1));
                                ptr_next   = AW'(lo_reg + CW'(1));
                                state_next = S_REM_SHIFT;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (hit_reg)
                            begin
                                result_next = make_result(ST_OK, lo_reg, fh_reg, count_reg);
                            end
                            else
                            begin
                                result_next = make_result(ST_NOT_FOUND, '0, '0, count_reg);
                            end
                        end
                        default:
                        begin
                            result_next = make_result(ST_NOT_FOUND, '0, '0, count_reg);
                        end
                    endcase
                end
            end
            S_READ:
            begin
                if (rd_key < key_reg)
                begin
                    lo_next = mid_reg + CW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
                if (rd_key == key_reg)
                begin
                    hit_next = 1'b1;
                    fh_next  = rd_handle;
                end
                state_next = S_SEARCH;
            end
            S_INS_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg + AW'(1);
                mem_wdata = mem_rdata_reg;
                if (ptr_reg == AW'(lo_reg))
                begin
                    state_next = S_INS_WRITE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg - AW'(1);
                    ptr_next  = ptr_reg - AW'(1);
                end
            end
            S_INS_WRITE:
            begin
                mem_we      = 1'b1;
                mem_waddr   = AW'(lo_reg);
                mem_wdata   = {key_reg, handle_reg};
                count_next  = count_reg + CW'(1);
                result_next = make_result(ST_OK, lo_reg, '0, count_reg + CW'(1));
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_REM_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg - AW'(1);
                mem_wdata = mem_rdata_reg;
                if (CW'(ptr_reg) + CW'(1) == count_reg)
                begin
                    count_next  = count_reg - CW'(1);
                    result_next = make_result(ST_OK, lo_reg, fh_reg, count_reg - CW'(1));
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg + AW'(1);
                    ptr_next  = ptr_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            hit_reg    <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        handle_reg <= handle_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        ptr_reg    <= ptr_next;
        fh_reg     <= fh_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= table_mem[mem_raddr];
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while an item is still in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start work");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_search_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (lo_reg <= hi_reg && hi_reg <= count_reg))
        else $error("search bounds out of order");

endmodule

FILE: tb/sv/sorted_key_table_search_tb.sv
// Testbench for the sorted key table: directed and random insert, remove, lookup and unused-opcode items.
`timescale 1ns / 1ps

module sorted_key_table_search_tb;

    import sktbl_pkg::*;

    localparam int TABLE_DEPTH = 256;
    localparam int HANDLE_BITS = 16;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_PER_PHASE = 255;
    localparam int MAX_GAP = 12;
    localparam int ITEM_BUDGET = 2000;
    localparam int WORST_ITEM_CYCLES = TABLE_DEPTH + 2 * 9 + 4 + MAX_GAP;
    localparam int LIMIT_CYCLES = ITEM_BUDGET * WORST_ITEM_CYCLES * 4;
    localparam int TAIL_CYCLES = 2 * WORST_ITEM_CYCLES;

    typedef struct {
        cmd_t cmd;
        bit   drain;
    } queued_cmd_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    command = '0;
    logic    busy;
    logic    done;
    result_t result;

    queued_cmd_t cmd_queue[$];
    result_t     pending_results[$];

    logic signed [31:0] shadow_keys [TABLE_DEPTH];
    logic [15:0]        shadow_handles [TABLE_DEPTH];
    int                 shadow_count = 0;
    int                 peak_entries = 0;

    logic signed [31:0] gen_keys[$];
    bit                 gen_held [int];

    int mismatches = 0;
    int cycle_count = 0;
    int burst_left = 1;
    int gap_left = 0;
    int op_seen [4] = '{0, 0, 0, 0};
    int status_seen [4] = '{0, 0, 0, 0};

    int ins_w [4] = '{20, 60, 35, 15};
    int rem_w [4] = '{50, 15, 30, 55};
    int look_w [4] = '{25, 20, 30, 25};

    sorted_key_table_search #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .HANDLE_BITS(HANDLE_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .done(done),
        .result(result)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    function automatic result_t table_op_result(cmd_t c);
        result_t            r;
        logic signed [31:0] k;
        int                 lo;
        int                 hi;
        int                 mid;
        int                 i;
        bit                 hit;
        k = c.key;
        lo = 0;
        hi = shadow_count;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if ($signed(shadow_keys[mid]) < $signed(k))
                lo = mid + 1;
            else
                hi = mid;
        end
        hit = (lo < shadow_count) && (shadow_keys[lo] == k);
        r.status = ST_NOT_FOUND;
        r.position = '0;
        r.found_handle = '0;
        case (c.opcode)
            OP_INSERT:
            begin
                if (hit)
                    r.status = ST_DUPLICATE;
                else if (shadow_count >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (i = shadow_count; i > lo; i--)
                    begin
                        shadow_keys[i] = shadow_keys[i - 1];
                        shadow_handles[i] = shadow_handles[i - 1];
                    end
                    shadow_keys[lo] = k;
                    shadow_handles[lo] = c.handle;
                    shadow_count++;
                    r.status = ST_OK;
                    r.position = 8'(lo);
                end
            end
            OP_REMOVE:
            begin
                if (hit)
                begin
                    r.found_handle = shadow_handles[lo];
                    for (i = lo; i + 1 < shadow_count; i++)
                    begin
                        shadow_keys[i] = shadow_keys[i + 1];
                        shadow_handles[i] = shadow_handles[i + 1];
                    end
                    shadow_count--;
                    r.status = ST_OK;
                    r.position = 8'(lo);
                end
            end
            OP_LOOKUP:
            begin
                if (hit)
                begin
                    r.found_handle = shadow_handles[lo];
                    r.status = ST_OK;
                    r.position = 8'(lo);
                end
            end
            default:
            begin
            end
        endcase
        r.entry_total = 9'(shadow_count);
        if (shadow_count > peak_entries)
            peak_entries = shadow_count;
        op_seen[c.opcode]++;
        status_seen[r.status]++;
        return r;
    endfunction

    task automatic gen_push(logic [1:0] op, logic signed [31:0] k, logic [15:0] h, bit drain);
        queued_cmd_t q;
        int          idx;
        idx = 0;
        q.cmd.opcode = op;
        q.cmd.key = k;
        q.cmd.handle = h;
        q.drain = drain;
        cmd_queue.push_back(q);
        if (op == OP_INSERT && !gen_held.exists(k) && gen_keys.size() < TABLE_DEPTH)
        begin
            gen_held[k] = 1'b1;
            gen_keys.push_back(k);
        end
        else if (op == OP_REMOVE && gen_held.exists(k))
        begin
            gen_held.delete(k);
            foreach (gen_keys[j])
                if (gen_keys[j] == k)
                    idx = j;
            gen_keys.delete(idx);
        end
    endtask

    function automatic logic signed [31:0] extreme_key();
        case ($urandom_range(0, 4))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_key(int held_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < held_pct && gen_keys.size() > 0)
            return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
        else if (r < held_pct + 15)
            return extreme_key();
        return $urandom();
    endfunction

    function automatic logic signed [31:0] fresh_key();
        logic signed [31:0] k;
        k = $urandom();
        while (gen_held.exists(k))
            k = $urandom();
        return k;
    endfunction

    // Driver: start stays high from item to item inside a burst, so each edge
    // assigns start and command exactly once.
    always @(posedge clk)
    begin : driver
        logic nxt_start;
        cmd_t nxt_cmd;
        if (!rst_n)
        begin
            start <= 1'b0;
            command <= '0;
        end
        else
        begin
            nxt_start = start;
            nxt_cmd = command;
            if (start && !busy)
            begin
                pending_results.push_back(table_op_result(command));
                void'(cmd_queue.pop_front());
                nxt_start = 1'b0;
            end
            if (!nxt_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (cmd_queue.size() > 0
                         && !(cmd_queue[0].drain && pending_results.size() != 0))
                begin
                    nxt_start = 1'b1;
                    nxt_cmd = cmd_queue[0].cmd;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
                    end
                end
            end
            start <= nxt_start;
            command <= nxt_cmd;
        end
    end

    always @(posedge clk)
    begin : monitor
        result_t exp_r;
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: status %0d position %0d handle %h total %0d",
                             result.status, result.position, result.found_handle,
                             result.entry_total);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result.status !== exp_r.status || result.position !== exp_r.position
                    || result.found_handle !== exp_r.found_handle
                    || result.entry_total !== exp_r.entry_total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result mismatch: expected status %0d position %0d ",
                                 exp_r.status, exp_r.position,
                                 "handle %h total %0d, ",
                                 exp_r.found_handle, exp_r.entry_total,
                                 "got status %0d position %0d handle %h total %0d",
                                 result.status, result.position,
                                 result.found_handle, result.entry_total);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                 r;
        logic [1:0]         op;
        logic signed [31:0] k;
        bit                 first;

        gen_push(OP_LOOKUP, 32'sd5, 16'h0000, 1'b0);
        gen_push(OP_REMOVE, 32'sd5, 16'hffff, 1'b0);
        gen_push(OP_INSERT, 32'sd0, 16'h0000, 1'b0);
        gen_push(OP_INSERT, 32'sh7fff_ffff, 16'hffff, 1'b0);
        gen_push(OP_INSERT, 32'sh8000_0000, 16'h1234, 1'b0);
        gen_push(OP_INSERT, -32'sd1, 16'haaaa, 1'b0);
        gen_push(OP_INSERT, 32'sd1, 16'h5555, 1'b0);
        gen_push(OP_INSERT, 32'sd0, 16'hbeef, 1'b0);
        gen_push(OP_LOOKUP, 32'sh8000_0000, 16'hffff, 1'b0);
        gen_push(OP_LOOKUP, 32'sh7fff_ffff, 16'h0000, 1'b0);
        gen_push(OP_LOOKUP, -32'sd1, 16'h0000, 1'b0);
        gen_push(OP_LOOKUP, 32'sd1, 16'h0000, 1'b0);
        gen_push(OP_LOOKUP, 32'sd2, 16'h0000, 1'b0);
        gen_push(OP_UNUSED, 32'sd0, 16'hffff, 1'b0);
        gen_push(OP_UNUSED, 32'sd9, 16'h0000, 1'b0);
        gen_push(OP_REMOVE, -32'sd1, 16'h0000, 1'b0);
        gen_push(OP_REMOVE, -32'sd1, 16'h0000, 1'b0);
        gen_push(OP_REMOVE, 32'sh8000_0000, 16'h0000, 1'b0);
        gen_push(OP_REMOVE, 32'sh7fff_ffff, 16'h0000, 1'b0);
        gen_push(OP_LOOKUP, 32'sd0, 16'h0000, 1'b0);

        // Fill the table to capacity, then hit the full and duplicate cases, a held-key lookup and an unused opcode.
        first = 1'b1;
        while (gen_keys.size() < TABLE_DEPTH)
        begin
            gen_push(OP_INSERT, fresh_key(), 16'($urandom_range(0, 65535)), first);
            first = 1'b0;
        end
        gen_push(OP_INSERT, fresh_key(), 16'($urandom_range(0, 65535)), 1'b0);
        gen_push(OP_INSERT, pick_key(100), 16'($urandom_range(0, 65535)), 1'b0);
        gen_push(OP_LOOKUP, pick_key(100), 16'($urandom_range(0, 65535)), 1'b0);
        gen_push(OP_UNUSED, pick_key(100), 16'($urandom_range(0, 65535)), 1'b0);

        for (int ph = 0; ph < 4; ph++)
        begin
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < ins_w[ph])
                    op = OP_INSERT;
                else if (r < ins_w[ph] + rem_w[ph])
                    op = OP_REMOVE;
                else if (r < ins_w[ph] + rem_w[ph] + look_w[ph])
                    op = OP_LOOKUP;
                else
                    op = OP_UNUSED;
                k = pick_key(op == OP_INSERT ? 20 : 70);
                gen_push(op, k, 16'($urandom_range(0, 65535)), n == 0);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (cmd_queue.size() != 0 || start)
            @(negedge clk);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Ran %0d inserts, %0d removes, %0d lookups, ",
                 op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_LOOKUP],
                 "%0d unused-opcode items; peak %0d entries",
                 op_seen[OP_UNUSED], peak_entries);
        $display("Outcomes: %0d done, %0d not found, %0d duplicate, ",
                 status_seen[ST_OK], status_seen[ST_NOT_FOUND], status_seen[ST_DUPLICATE],
                 "%0d table full; %0d mismatches",
                 status_seen[ST_FULL], mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
